// ----- rtl/name_substring_ext_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the file name filter
// Shared concurrent assertion forms, each clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef NAME_SUBSTRING_EXT_FILTER_DEFINES_SVH
`define NAME_SUBSTRING_EXT_FILTER_DEFINES_SVH

// Same-cycle implication.
`define NSEF_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("nsef assertion failed");

// Next-cycle implication.
`define NSEF_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("nsef assertion failed");

`endif

// ----- rtl/nsef_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef_pkg
// Types, codes, character folding and the extension category table of the
// file name filter.
// ----------------------------------------------------------------------------
package nsef_pkg;

  localparam int CHAR_W       = 16;
  localparam int MAX_EXT      = 5;
  localparam int EXT_LEN_W    = 3;
  localparam int EXT_LEN_SAT  = MAX_EXT + 1;
  localparam int NUM_CAT      = 5;
  localparam int QUEUE_DEPTH  = 4;
  localparam int EXT_TEXT_MAX = 4;
  localparam int EXT_TABLE_SIZE = 26;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [MAX_EXT-1:0] ext_chars_t;

  // Item kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_NAME   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  localparam char_t CH_DOT       = 16'h002E;
  localparam char_t CH_SLASH     = 16'h002F;
  localparam char_t CH_BACKSLASH = 16'h005C;
  localparam char_t CH_UPPER_A   = 16'h0041;
  localparam char_t CH_UPPER_Z   = 16'h005A;
  localparam char_t CASE_OFFSET  = 16'd32;

  // Extension categories, one bit each in the class mask.
  localparam logic [2:0] CAT_PDF     = 3'd0;
  localparam logic [2:0] CAT_DOC     = 3'd1;
  localparam logic [2:0] CAT_ARCHIVE = 3'd2;
  localparam logic [2:0] CAT_IMAGE   = 3'd3;
  localparam logic [2:0] CAT_VIDEO   = 3'd4;

  // Classified item handed from the front end to the matcher.
  typedef struct packed {
    kind_t kind;
    char_t ch;
    logic  last;
    logic  is_dot;
    logic  is_sep;
  } queue_item_t;

  // Known extension: length, text (first character in the top byte), category.
  typedef struct packed {
    logic [EXT_LEN_W-1:0] len;
    logic [8*EXT_TEXT_MAX-1:0] text;
    logic [2:0] cat;
  } ext_entry_t;

  localparam ext_entry_t EXT_TABLE [EXT_TABLE_SIZE] = '{
    '{3'd3, {"pdf", 8'h00}, CAT_PDF},
    '{3'd3, {"doc", 8'h00}, CAT_DOC},
    '{3'd4, "docx", CAT_DOC},
    '{3'd3, {"odt", 8'h00}, CAT_DOC},
    '{3'd3, {"rtf", 8'h00}, CAT_DOC},
    '{3'd3, {"txt", 8'h00}, CAT_DOC},
    '{3'd3, {"zip", 8'h00}, CAT_ARCHIVE},
    '{3'd3, {"rar", 8'h00}, CAT_ARCHIVE},
    '{3'd2, {"7z", 16'h0000}, CAT_ARCHIVE},
    '{3'd3, {"tar", 8'h00}, CAT_ARCHIVE},
    '{3'd2, {"gz", 16'h0000}, CAT_ARCHIVE},
    '{3'd3, {"jpg", 8'h00}, CAT_IMAGE},
    '{3'd4, "jpeg", CAT_IMAGE},
    '{3'd3, {"png", 8'h00}, CAT_IMAGE},
    '{3'd3, {"gif", 8'h00}, CAT_IMAGE},
    '{3'd3, {"bmp", 8'h00}, CAT_IMAGE},
    '{3'd4, "webp", CAT_IMAGE},
    '{3'd3, {"tif", 8'h00}, CAT_IMAGE},
    '{3'd4, "tiff", CAT_IMAGE},
    '{3'd3, {"mp4", 8'h00}, CAT_VIDEO},
    '{3'd3, {"mkv", 8'h00}, CAT_VIDEO},
    '{3'd3, {"avi", 8'h00}, CAT_VIDEO},
    '{3'd3, {"mov", 8'h00}, CAT_VIDEO},
    '{3'd4, "webm", CAT_VIDEO},
    '{3'd3, {"wmv", 8'h00}, CAT_VIDEO},
    '{3'd3, {"flv", 8'h00}, CAT_VIDEO}
  };

  // Fold ASCII upper case letters to lower case; other code units pass.
  function automatic char_t fold(input char_t c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Set of categories whose table entries equal the given extension.
  function automatic logic [NUM_CAT-1:0] ext_category(input logic [EXT_LEN_W-1:0] len,
                                                      input ext_chars_t ch);
    logic [NUM_CAT-1:0] cat;
    logic same;
    cat = '0;
    for (int i = 0; i < EXT_TABLE_SIZE; i++) begin
      same = (len == EXT_TABLE[i].len);
      for (int k = 0; k < EXT_TEXT_MAX; k++) begin
        if (k < int'(len) &&
            ch[k] != {8'h00, EXT_TABLE[i].text[8*(EXT_TEXT_MAX-1-k) +: 8]}) begin
          same = 1'b0;
        end
      end
      if (same) begin
        cat[EXT_TABLE[i].cat] = 1'b1;
      end
    end
    return cat;
  endfunction

endpackage

// ----- rtl/nsef_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef channel interfaces
// Valid/ready channels for input items, results and the class mask write.
// ----------------------------------------------------------------------------

// Input item channel.
interface nsef_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] char_code;
  logic        last;

  modport source (output valid, kind, char_code, last, input ready);
  modport sink (input valid, kind, char_code, last, output ready);
endinterface

// Result channel.
interface nsef_result_if;
  logic valid;
  logic ready;
  logic substring_hit;
  logic extension_hit;
  logic accepted;

  modport source (output valid, substring_hit, extension_hit, accepted, input ready);
  modport sink (input valid, substring_hit, extension_hit, accepted, output ready);
endinterface

// Class mask write channel.
interface nsef_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] ext_class_mask;

  modport source (output valid, ext_class_mask, input ready);
  modport sink (input valid, ext_class_mask, output ready);
endinterface

// ----- rtl/nsef_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef_front
// Accepts input items, folds the character and tags dots and path
// separators; unused kinds are dropped here.
// ----------------------------------------------------------------------------
module nsef_front (
  nsef_item_if.sink            item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output nsef_pkg::queue_item_t push_data
);

  nsef_pkg::kind_t kind;
  nsef_pkg::char_t ch;

  // Decode and fold.
  always_comb begin
    kind = nsef_pkg::kind_t'(item.kind);
    ch   = nsef_pkg::fold(item.char_code);
  end

  // Items are taken whenever the queue has room.
  assign item.ready = push_ready;
  assign push_valid = item.valid && (kind != nsef_pkg::KIND_UNUSED);

  // Classified item for the matcher.
  always_comb begin
    push_data.kind   = kind;
    push_data.ch     = ch;
    push_data.last   = item.last;
    push_data.is_dot = (ch == nsef_pkg::CH_DOT);
    push_data.is_sep = (ch == nsef_pkg::CH_SLASH) || (ch == nsef_pkg::CH_BACKSLASH);
  end

endmodule

// ----- rtl/nsef_queue.sv -----
`timescale 1ns / 1ps
`include "name_substring_ext_filter_defines.svh"
// ----------------------------------------------------------------------------
// nsef_queue
// Short register FIFO between the front end and the matcher.
// ----------------------------------------------------------------------------
module nsef_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  nsef_pkg::queue_item_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output nsef_pkg::queue_item_t pop_data
);

  localparam int PtrW = $clog2(nsef_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(nsef_pkg::QUEUE_DEPTH + 1);

  nsef_pkg::queue_item_t slots [nsef_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push_fire;
  logic pop_fire;

  // Handshake status.
  assign push_ready = (count != CntW'(nsef_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `NSEF_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CntW'(nsef_pkg::QUEUE_DEPTH))
  `NSEF_ASSERT_NEXT(a_count_up, clk, rst, push_fire && !pop_fire, count == $past(count) + 1'b1)
  `NSEF_ASSERT_NEXT(a_count_down, clk, rst, pop_fire && !push_fire, count == $past(count) - 1'b1)

endmodule

// ----- rtl/nsef_back.sv -----
`timescale 1ns / 1ps
`include "name_substring_ext_filter_defines.svh"
// ----------------------------------------------------------------------------
// nsef_back
// Holds the needle, runs the bit-parallel prefix match and the extension
// tracker, and presents one result per name in an output register.
// ----------------------------------------------------------------------------
module nsef_back #(
  parameter int MAX_NEEDLE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  nsef_pkg::queue_item_t             pop_data,
  input  logic [nsef_pkg::NUM_CAT-1:0]      ext_class_mask,
  nsef_result_if.source                     result
);

  localparam int ExtLenW = nsef_pkg::EXT_LEN_W;

  // Needle: one entry per position; fill level kept as a thermometer.
  nsef_pkg::char_t needle_store [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] needle_valid;
  logic [MAX_NEEDLE-1:0] needle_last;

  // Per-name state.
  logic [MAX_NEEDLE-1:0] pm;
  logic                  hit_seen;
  logic                  dot_seen;
  logic [ExtLenW-1:0]    ext_len;
  nsef_pkg::ext_chars_t  ext_chars;

  // Output register.
  logic res_valid;
  logic res_sub;
  logic res_ext;

  logic                  fire;
  logic                  is_name;
  logic [MAX_NEEDLE:0]   pm_ext;
  logic [MAX_NEEDLE-1:0] char_eq;
  logic [MAX_NEEDLE-1:0] pm_next;
  logic [MAX_NEEDLE-1:0] valid_grown;
  logic                  hit_now;
  logic                  dot_next;
  logic [ExtLenW-1:0]    len_next;
  nsef_pkg::ext_chars_t  chars_next;
  logic [nsef_pkg::NUM_CAT-1:0] cat;
  logic                  sub_hit;
  logic                  ext_hit;

  // An item is taken when the result slot is free or being emptied.
  assign pop_ready = !res_valid || result.ready;
  assign fire      = pop_valid && pop_ready;
  assign is_name   = (pop_data.kind == nsef_pkg::KIND_NAME);

  // Shift-and step: every needle position compares against the character.
  assign pm_ext      = {pm, 1'b1};
  assign valid_grown = MAX_NEEDLE'({needle_valid, 1'b1});
  always_comb begin
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      char_eq[j] = (needle_store[j] == pop_data.ch);
    end
  end
  assign pm_next = needle_valid & char_eq & pm_ext[MAX_NEEDLE-1:0];
  assign hit_now = |(pm_next & needle_last);

  // Extension tracking: last dot after the last separator.
  always_comb begin
    dot_next   = dot_seen;
    len_next   = ext_len;
    chars_next = ext_chars;
    if (pop_data.is_dot) begin
      dot_next = 1'b1;
      len_next = '0;
    end else if (pop_data.is_sep) begin
      dot_next = 1'b0;
      len_next = '0;
    end else if (dot_seen) begin
      for (int i = 0; i < nsef_pkg::MAX_EXT; i++) begin
        if (ext_len == ExtLenW'(i)) begin
          chars_next[i] = pop_data.ch;
        end
      end
      if (ext_len < ExtLenW'(nsef_pkg::EXT_LEN_SAT)) begin
        len_next = ext_len + 1'b1;
      end
    end
  end

  // Result for a name that ends with this character.
  always_comb begin
    cat     = nsef_pkg::ext_category(len_next, chars_next);
    sub_hit = !needle_valid[0] || hit_seen || hit_now;
    ext_hit = (ext_class_mask == '0) ||
              (dot_next && (len_next != '0) &&
               (len_next <= ExtLenW'(nsef_pkg::MAX_EXT)) && |(cat & ext_class_mask));
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_valid <= '0;
      needle_last  <= '0;
      pm           <= '0;
      hit_seen     <= 1'b0;
      dot_seen     <= 1'b0;
      ext_len      <= '0;
      res_valid    <= 1'b0;
    end else begin
      // Result slot: filled by a final name character, emptied when taken.
      if (fire && is_name && pop_data.last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        case (pop_data.kind)
          nsef_pkg::KIND_CLEAR: begin
            needle_valid <= '0;
            needle_last  <= '0;
            pm           <= '0;
            hit_seen     <= 1'b0;
            dot_seen     <= 1'b0;
            ext_len      <= '0;
          end
          nsef_pkg::KIND_APPEND: begin
            if (!needle_valid[MAX_NEEDLE-1]) begin
              needle_valid <= valid_grown;
              needle_last  <= valid_grown & ~needle_valid;
            end
            pm       <= '0;
            hit_seen <= 1'b0;
            dot_seen <= 1'b0;
            ext_len  <= '0;
          end
          nsef_pkg::KIND_NAME: begin
            if (pop_data.last) begin
              pm       <= '0;
              hit_seen <= 1'b0;
              dot_seen <= 1'b0;
              ext_len  <= '0;
            end else begin
              pm       <= pm_next;
              hit_seen <= hit_seen || hit_now;
              dot_seen <= dot_next;
              ext_len  <= len_next;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Needle characters: the entry just past the fill level takes the append.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      if (fire && pop_data.kind == nsef_pkg::KIND_APPEND &&
          valid_grown[j] && !needle_valid[j]) begin
        needle_store[j] <= pop_data.ch;
      end
    end
  end

  // Extension characters and result payload.
  always_ff @(posedge clk) begin
    if (fire && is_name) begin
      ext_chars <= chars_next;
      if (pop_data.last) begin
        res_sub <= sub_hit;
        res_ext <= ext_hit;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.substring_hit = res_sub;
  assign result.extension_hit = res_ext;
  assign result.accepted      = res_sub && res_ext;

  `NSEF_ASSERT_IMPL(a_needle_thermo, clk, rst, 1'b1,
                    (needle_valid & (needle_valid + 1'b1)) == '0)
  `NSEF_ASSERT_IMPL(a_needle_last, clk, rst, 1'b1,
                    needle_last == (needle_valid & ~(needle_valid >> 1)))
  `NSEF_ASSERT_IMPL(a_pm_in_needle, clk, rst, 1'b1, (pm & ~needle_valid) == '0)
  `NSEF_ASSERT_IMPL(a_ext_len_sat, clk, rst, 1'b1,
                    ext_len <= ExtLenW'(nsef_pkg::EXT_LEN_SAT))

endmodule

// ----- rtl/name_substring_ext_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_substring_ext_filter
// Case-insensitive needle search and extension category filter over file
// names streamed one UTF-16 code unit per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its queue has room:
// every needle position is compared against the incoming character in the
// same cycle, so the prefix-match state is updated as each character is
// taken. An accepted item passes through a four-entry queue and the matcher;
// the result of a name is captured in the output register when its last
// character leaves the queue, and it waits there while later items keep
// flowing until the queue fills. Needle items also abandon a name in
// progress. The class mask may only be written while the block is idle.
module name_substring_ext_filter #(
  parameter int MAX_NEEDLE = 64
) (
  input  logic          clk,
  input  logic          rst,
  nsef_item_if.sink     item,
  nsef_result_if.source result,
  nsef_cfg_if.sink      cfg
);

  logic                  push_valid;
  logic                  push_ready;
  nsef_pkg::queue_item_t push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  nsef_pkg::queue_item_t pop_data;
  logic [nsef_pkg::NUM_CAT-1:0] ext_class_mask;

  // Class mask register; writes are always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_class_mask <= '0;
    end else if (cfg.valid) begin
      ext_class_mask <= cfg.ext_class_mask;
    end
  end

  // Front end: accept and classify.
  nsef_front u_front (
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue.
  nsef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: matching and result register.
  nsef_back #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .ext_class_mask (ext_class_mask),
    .result         (result)
  );

endmodule
